[rtl/core/irigb_pkg.sv]
package irigb_pkg;

  // Timer and register width
  localparam int TIMER_BITS = 32;
  // APB address width: four 32-bit registers at 4*i
  localparam int CFG_AW     = 4;

  typedef logic [TIMER_BITS-1:0] tick_t;

  typedef enum logic [3:0] {
    ST_BUFFERING  = 4'd0,
    ST_ZERO       = 4'd1,
    ST_ONE        = 4'd2,
    ST_P          = 4'd3,
    ST_POL_FIRST  = 4'd4,
    ST_POL_SECOND = 4'd5,
    ST_POL_THIRD  = 4'd6,
    ST_ERR_ONE    = 4'd7,
    ST_ERR_P      = 4'd8,
    ST_ERR_ZERO   = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,  // awaiting opening rise
    PH_HIGH = 2'd1,  // awaiting fall
    PH_LOW  = 2'd2   // awaiting closing rise
  } phase_t;

  typedef enum logic [1:0] {
    REG_TWO_MS   = 2'd0,
    REG_FIVE_MS  = 2'd1,
    REG_EIGHT_MS = 2'd2,
    REG_TOL      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    tick_t two_ms;
    tick_t five_ms;
    tick_t eight_ms;
    tick_t tol;
  } cfg_t;

  localparam tick_t RST_TWO_MS   = tick_t'(2000);
  localparam tick_t RST_FIVE_MS  = tick_t'(5000);
  localparam tick_t RST_EIGHT_MS = tick_t'(8000);
  localparam tick_t RST_TOL      = tick_t'(500);

  typedef struct packed {
    status_t status;
    tick_t   stamp;
    logic    stamp_valid;
  } result_t;

  // n - t < w < n + t, exact; lower bound always met when t > n
  function automatic logic in_window(input tick_t w, input tick_t n, input tick_t t);
    logic above;
    logic below;
    above = (n < t) || (w > (n - t));
    below = (w < n) || ((w - n) < t);
    return above && below;
  endfunction

endpackage

[rtl/core/irigb_classify.sv]
module irigb_classify (
  input  irigb_pkg::tick_t   hi_width,
  input  irigb_pkg::tick_t   lo_width,
  input  irigb_pkg::cfg_t    cfg,
  output irigb_pkg::status_t status
);
  import irigb_pkg::*;

  logic hi_in_five, lo_in_five, hi_in_eight, lo_in_two, hi_in_two, lo_in_eight;

  assign hi_in_five  = in_window(hi_width, cfg.five_ms,  cfg.tol);
  assign lo_in_five  = in_window(lo_width, cfg.five_ms,  cfg.tol);
  assign hi_in_eight = in_window(hi_width, cfg.eight_ms, cfg.tol);
  assign lo_in_two   = in_window(lo_width, cfg.two_ms,   cfg.tol);
  assign hi_in_two   = in_window(hi_width, cfg.two_ms,   cfg.tol);
  assign lo_in_eight = in_window(lo_width, cfg.eight_ms, cfg.tol);

  // priority: 5 ms high first, then long high (P), else short high (zero)
  always_comb begin
    if (hi_in_five) begin
      status = lo_in_five ? ST_ONE : ST_ERR_ONE;
    end else if (hi_width > cfg.five_ms) begin
      status = (hi_in_eight && lo_in_two) ? ST_P : ST_ERR_P;
    end else begin
      status = (hi_in_two && lo_in_eight) ? ST_ZERO : ST_ERR_ZERO;
    end
  end

endmodule

[rtl/core/irigb_tracker.sv]
module irigb_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               rising,
  input  irigb_pkg::tick_t   capt,
  input  irigb_pkg::cfg_t    cfg,
  output irigb_pkg::result_t res
);
  import irigb_pkg::*;

  phase_t  phase_r, phase_nxt;
  tick_t   rise_r, rise_nxt;
  tick_t   fall_r, fall_nxt;
  tick_t   hi_width, lo_width;
  status_t class_status;

  assign hi_width = fall_r - rise_r;
  assign lo_width = capt - fall_r;

  irigb_classify u_classify (
    .hi_width (hi_width),
    .lo_width (lo_width),
    .cfg      (cfg),
    .status   (class_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rise_r  <= '0;
      fall_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    rise_nxt        = rise_r;
    fall_nxt        = fall_r;
    res.status      = ST_BUFFERING;
    res.stamp       = '0;
    res.stamp_valid = 1'b0;
    case (phase_r)
      PH_HIGH: begin
        if (rising) begin
          phase_nxt  = PH_IDLE;
          res.status = ST_POL_SECOND;
        end else begin
          fall_nxt  = capt;
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        if (!rising) begin
          phase_nxt  = PH_IDLE;
          res.status = ST_POL_THIRD;
        end else begin
          res.status      = class_status;
          res.stamp       = rise_r;
          res.stamp_valid = 1'b1;
          rise_nxt        = capt;
          phase_nxt       = PH_HIGH;
        end
      end
      default: begin
        if (!rising) begin
          res.status = ST_POL_FIRST;
        end else begin
          rise_nxt  = capt;
          phase_nxt = PH_HIGH;
        end
      end
    endcase
  end

endmodule

[rtl/core/irig_b_symbol_classifier.sv]
// Channel | Port group        | Beat payload
// --------+-------------------+-------------------------------------------------
// in      | in_t*  (slave)    | tdata: capture_time; tuser: edge_is_rising
// out     | out_t* (master)   | tdata: symbol_timestamp;
//         |                   | tuser: symbol_status, timestamp_valid
// cfg     | cfg_p* (APB)      | 4 x 32-bit regs at 0x0, 0x4, 0x8, 0xC
//
// One beat in, one beat out; a new edge can be taken every cycle while the
// output is not stalled. Path: input register, then tracker/classifier into the
// result register. The classifier's window compares set the cycle path.
// Synchronous active-low reset clears the phase tracker, both stored edge
// times and the registers to 2000/5000/8000/500 ticks.
// Out-side stall holds the result register; the input register keeps taking
// beats until it too is full.
module irig_b_symbol_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  // in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [31:0] capture_time
  input  logic [0:0]                       in_tuser,   // [0] edge_is_rising
  // out
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] symbol_timestamp
  output logic [4:0]                       out_tuser,  // [3:0] symbol_status,
                                                       // [4] timestamp_valid
  // cfg
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [irigb_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import irigb_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  logic     s1_valid_r;
  logic     s1_rising_r;
  tick_t    s1_time_r;

  logic     out_valid_r;
  result_t  res_r;
  result_t  res;

  logic     adv;   // result register free or being drained
  logic     step;  // held edge moves into the result register

  // ---------------- register file ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.two_ms   <= RST_TWO_MS;
      cfg_r.five_ms  <= RST_FIVE_MS;
      cfg_r.eight_ms <= RST_EIGHT_MS;
      cfg_r.tol      <= RST_TOL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TWO_MS:   cfg_r.two_ms   <= cfg_pwdata;
        REG_FIVE_MS:  cfg_r.five_ms  <= cfg_pwdata;
        REG_EIGHT_MS: cfg_r.eight_ms <= cfg_pwdata;
        REG_TOL:      cfg_r.tol      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TWO_MS:   cfg_prdata = cfg_r.two_ms;
      REG_FIVE_MS:  cfg_prdata = cfg_r.five_ms;
      REG_EIGHT_MS: cfg_prdata = cfg_r.eight_ms;
      REG_TOL:      cfg_prdata = cfg_r.tol;
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign adv       = !out_valid_r || out_tready;
  assign step      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_rising_r <= in_tuser[0];
      s1_time_r   <= in_tdata;
    end
  end

  // phase tracker and classifier; state advances only on step
  irigb_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .rising (s1_rising_r),
    .capt   (s1_time_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.stamp;
  assign out_tuser  = {res_r.stamp_valid, res_r.status};

`ifndef SYNTHESIS
  // a classified period carries a symbol or width-error code
  a_valid_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.stamp_valid |->
      (res_r.status == ST_ZERO || res_r.status == ST_ONE || res_r.status == ST_P ||
       res_r.status == ST_ERR_ONE || res_r.status == ST_ERR_P ||
       res_r.status == ST_ERR_ZERO))
    else $error("classified period with non-class status");

  // no period classified: zero timestamp, buffering or polarity code
  a_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.stamp_valid |->
      (res_r.stamp == '0) &&
      (res_r.status == ST_BUFFERING || res_r.status == ST_POL_FIRST ||
       res_r.status == ST_POL_SECOND || res_r.status == ST_POL_THIRD))
    else $error("unclassified beat with timestamp or class status");

  // both stages full and output stalled: no new beat may be taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full");

  // a step always fills the result register on the next edge
  a_step_fill: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("step lost");
`endif

endmodule
